/* design/cell_voltage_scan_monitor_top_macros.svh */
// Assertion macros for the cell voltage scan monitor checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef CELL_VOLTAGE_SCAN_MONITOR_TOP_MACROS_SVH
`define CELL_VOLTAGE_SCAN_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CVSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* design/cvsm_pkg.sv */
// Shared types and constants of the cell voltage scan monitor.
// No dependencies; every other file of the block but the macros header imports this package.
package cvsm_pkg;

  localparam int MAX_CELLS  = 256;
  localparam int VOLT_W     = 16;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 8;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int STEP_W     = 5;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic [CODE_W-1:0] CODE_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_OVER  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_UNDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 1'd1;

  // One closed scan, handed from the front to the back.
  typedef struct packed {
    logic [VOLT_W-1:0] max_voltage;
    logic [VOLT_W-1:0] min_voltage;
    logic [SUM_W-1:0]  total_voltage;
    logic [CNT_W-1:0]  cell_count;
    logic [CODE_W-1:0] scan_status;
    logic [CODE_W-1:0] record_code;
    logic [IDX_W-1:0]  record_index;
    logic [VOLT_W-1:0] record_value;
  } scan_sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

/* design/cvsm_ifs.sv */
// Handshake interfaces of the cell voltage scan monitor: sample and result words.
// Depends on cvsm_pkg for field widths.
interface cvsm_in_if;
  import cvsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] cell_voltage;
  logic              last_cell;

  modport source (output valid, output cell_voltage, output last_cell, input ready);
  modport sink   (input valid, input cell_voltage, input last_cell, output ready);
endinterface

interface cvsm_out_if;
  import cvsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] max_voltage;
  logic [VOLT_W-1:0] min_voltage;
  logic [SUM_W-1:0]  total_voltage;
  logic [VOLT_W-1:0] mean_voltage;
  logic [CODE_W-1:0] scan_status;
  logic [CODE_W-1:0] record_code;
  logic [IDX_W-1:0]  record_index;
  logic [VOLT_W-1:0] record_value;

  modport source (output valid, output max_voltage, output min_voltage,
                  output total_voltage, output mean_voltage, output scan_status,
                  output record_code, output record_index, output record_value,
                  input ready);
  modport sink   (input valid, input max_voltage, input min_voltage,
                  input total_voltage, input mean_voltage, input scan_status,
                  input record_code, input record_index, input record_value,
                  output ready);
endinterface

/* design/cvsm_front.sv */
// Front end: accepts sample words, tracks max/min/sum/count and the error record.
// Depends on cvsm_pkg; pushes one scan_sum_t per closed scan into the queue.
module cvsm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cvsm_pkg::cfg_wr_t          cfg,
  input  logic                       acc,
  input  logic [cvsm_pkg::VOLT_W-1:0] cell_voltage,
  input  logic                       last_cell,
  output logic                       push,
  output cvsm_pkg::scan_sum_t        push_data
);
  import cvsm_pkg::*;

  logic [VOLT_W-1:0] upper_r, lower_r;
  logic [VOLT_W-1:0] max_r, max_nxt;
  logic [VOLT_W:0]   min_r, min_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CODE_W-1:0] rcode_r, rcode_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;
  logic [VOLT_W-1:0] rval_r, rval_nxt;
  logic              new_max, new_min, close;
  logic [CODE_W-1:0] status;

  always_comb begin
    new_max   = cell_voltage > max_r;
    new_min   = {1'b0, cell_voltage} < min_r;
    max_nxt   = new_max ? cell_voltage : max_r;
    min_nxt   = new_min ? {1'b0, cell_voltage} : min_r;
    sum_nxt   = sum_r + SUM_W'(cell_voltage);
    cnt_nxt   = cnt_r + CNT_W'(1);
    rcode_nxt = rcode_r;
    ridx_nxt  = ridx_r;
    rval_nxt  = rval_r;
    // under check runs second so it wins on a cell that is both
    if (new_max && cell_voltage > upper_r) begin
      rcode_nxt = CODE_OVER;
      ridx_nxt  = cnt_r[IDX_W-1:0];
      rval_nxt  = cell_voltage;
    end
    if (new_min && cell_voltage < lower_r) begin
      rcode_nxt = CODE_UNDER;
      ridx_nxt  = cnt_r[IDX_W-1:0];
      rval_nxt  = cell_voltage;
    end
    close = last_cell || (cnt_nxt == CNT_W'(MAX_CELLS));
    if (max_nxt > upper_r) begin
      status = CODE_OVER;
    end else if (min_nxt < {1'b0, lower_r}) begin
      status = CODE_UNDER;
    end else begin
      status = CODE_NONE;
    end
    push                    = acc && close;
    push_data.max_voltage   = max_nxt;
    push_data.min_voltage   = min_nxt[VOLT_W-1:0];
    push_data.total_voltage = sum_nxt;
    push_data.cell_count    = cnt_nxt;
    push_data.scan_status   = status;
    push_data.record_code   = rcode_nxt;
    push_data.record_index  = ridx_nxt;
    push_data.record_value  = rval_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '1;
      lower_r <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_UPPER_LIMIT: upper_r <= cfg.data[VOLT_W-1:0];
        REG_LOWER_LIMIT: lower_r <= cfg.data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      min_r   <= '1;
      sum_r   <= '0;
      cnt_r   <= '0;
      rcode_r <= CODE_NONE;
      ridx_r  <= '0;
      rval_r  <= '0;
    end else if (acc) begin
      rcode_r <= rcode_nxt;
      ridx_r  <= ridx_nxt;
      rval_r  <= rval_nxt;
      // restart the scan figures once a scan closes
      if (close) begin
        max_r <= '0;
        min_r <= '1;
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        max_r <= max_nxt;
        min_r <= min_nxt;
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end
endmodule

/* design/cvsm_queue.sv */
// Short queue of closed-scan summaries between front and back.
// Depends on cvsm_pkg for scan_sum_t and depth constants.
module cvsm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cvsm_pkg::scan_sum_t push_data,
  input  logic                pop,
  output cvsm_pkg::scan_sum_t pop_data,
  output cvsm_pkg::q_stat_t   stat
);
  import cvsm_pkg::*;

  scan_sum_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign pop_data   = slot_r[rd_r];
  assign stat.full  = fill_r == (QPTR_W+1)'(QDEPTH);
  assign stat.empty = fill_r == '0;

  always_comb begin
    fill_nxt = fill_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + (QPTR_W+1)'(1);
      2'b01:   fill_nxt = fill_r - (QPTR_W+1)'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      fill_r <= fill_nxt;
    end
  end
endmodule

/* design/cvsm_back.sv */
// Back end: takes a scan summary, divides total by count one bit a cycle,
// and drives the output register. Depends on cvsm_pkg.
module cvsm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cvsm_pkg::q_stat_t   qstat,
  input  cvsm_pkg::scan_sum_t qdata,
  output logic                pop,
  cvsm_out_if.source          out_ch
);
  import cvsm_pkg::*;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  scan_sum_t         hold_r;
  logic [SUM_W-1:0]  dq_r;
  logic [IDX_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  trial;
  logic              fit, load_out;
  logic              ovalid_r;
  scan_sum_t         opay_r;
  logic [VOLT_W-1:0] omean_r;

  always_comb begin
    trial     = {rem_r, dq_r[SUM_W-1]};
    fit       = trial >= hold_r.cell_count;
    pop       = (state_r == BK_IDLE) && !qstat.empty;
    load_out  = (state_r == BK_DONE) && (!ovalid_r || out_ch.ready);
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!qstat.empty) state_nxt = BK_DIV;
      BK_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = BK_DONE;
      BK_DONE: if (load_out) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        hold_r <= qdata;
        dq_r   <= qdata.total_voltage;
        rem_r  <= '0;
        step_r <= '0;
      end
      BK_DIV: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        rem_r  <= fit ? IDX_W'(trial - hold_r.cell_count) : trial[IDX_W-1:0];
        dq_r   <= {dq_r[SUM_W-2:0], fit};
        step_r <= step_r + STEP_W'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      opay_r  <= hold_r;
      omean_r <= dq_r[VOLT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.max_voltage   = opay_r.max_voltage;
  assign out_ch.min_voltage   = opay_r.min_voltage;
  assign out_ch.total_voltage = opay_r.total_voltage;
  assign out_ch.mean_voltage  = omean_r;
  assign out_ch.scan_status   = opay_r.scan_status;
  assign out_ch.record_code   = opay_r.record_code;
  assign out_ch.record_index  = opay_r.record_index;
  assign out_ch.record_value  = opay_r.record_value;
endmodule

/* design/cell_voltage_scan_monitor_top.sv */
// Top level of the cell voltage scan monitor: front, summary queue, back.
// Depends on cvsm_pkg, cvsm_ifs, cvsm_front, cvsm_queue and cvsm_back.
//
//   channel  | dir | word                            | when moved
//   ---------+-----+---------------------------------+---------------------------
//   in_ch    | in  | cell_voltage, last_cell         | valid && ready
//   out_ch   | out | scan figures, status, record    | valid && ready, once a scan
//   cfg_*    | in  | upper/lower limit write         | cfg_we high
//
// Cycles: one sample word is taken every cycle while the summary queue has room.
// Each closed scan is loaded into the back end, run through the one-bit-a-cycle restoring
// divide of total by count, then moved into the output register.
// Reset: synchronous, active low; clears limits to 65535/0, scan figures and record.
// Stalls: in_ch.ready drops while the four-entry queue is full; a waiting result
// holds the back end in its done state, the front keeps taking samples.
module cell_voltage_scan_monitor_top (
  input  logic                           clk,
  input  logic                           rst_n,
  cvsm_in_if.sink                        in_ch,
  cvsm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [cvsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cvsm_pkg::*;

  cfg_wr_t   cfg;
  logic      acc, push, pop;
  scan_sum_t push_data, pop_data;
  q_stat_t   qstat;

  // bundle the config write for the front
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // take a sample only while the queue can absorb a possible scan close
  assign in_ch.ready = !qstat.full;
  assign acc         = in_ch.valid && !qstat.full;

  cvsm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .acc          (acc),
    .cell_voltage (in_ch.cell_voltage),
    .last_cell    (in_ch.last_cell),
    .push         (push),
    .push_data    (push_data)
  );

  // decouple sample intake from the slow divide
  cvsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  cvsm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qstat  (qstat),
    .qdata  (pop_data),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule

/* design/cvsm_checker.sv */
// Port-level checker of the cell voltage scan monitor, bound to the top level.
// Depends on cvsm_pkg and cell_voltage_scan_monitor_top_macros.svh.
`include "cell_voltage_scan_monitor_top_macros.svh"

module cvsm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cvsm_pkg::VOLT_W-1:0]   max_voltage,
  input logic [cvsm_pkg::VOLT_W-1:0]   min_voltage,
  input logic [cvsm_pkg::VOLT_W-1:0]   mean_voltage,
  input logic [cvsm_pkg::CODE_W-1:0]   scan_status,
  input logic [cvsm_pkg::CODE_W-1:0]   record_code
);
  import cvsm_pkg::*;

  `CVSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mean_voltage))
  `CVSM_ASSERT_IMP(a_min_le_max, out_valid, min_voltage <= max_voltage)
  `CVSM_ASSERT_IMP(a_mean_range, out_valid,
                   mean_voltage >= min_voltage && mean_voltage <= max_voltage)
  `CVSM_ASSERT_IMP(a_codes, out_valid, scan_status <= CODE_UNDER && record_code <= CODE_UNDER)
endmodule

bind cell_voltage_scan_monitor_top cvsm_checker u_cvsm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .max_voltage  (out_ch.max_voltage),
  .min_voltage  (out_ch.min_voltage),
  .mean_voltage (out_ch.mean_voltage),
  .scan_status  (out_ch.scan_status),
  .record_code  (out_ch.record_code)
);

/* tb/cvsm_scan_checker.sv */
`timescale 1ns / 100ps
// Scan checker for the cell voltage scan monitor: watches sample, result and limit ports.
// Depends on cvsm_pkg and the cvsm_in_if / cvsm_out_if interfaces.
module cvsm_scan_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  cvsm_in_if                              in_ch,
  cvsm_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [cvsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvsm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_scans
);
  import cvsm_pkg::*;

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [VOLT_W-1:0] max_v;
    logic [VOLT_W-1:0] min_v;
    logic [SUM_W-1:0]  total_v;
    logic [VOLT_W-1:0] mean_v;
    logic [CODE_W-1:0] status;
    logic [CODE_W-1:0] rec_code;
    logic [IDX_W-1:0]  rec_idx;
    logic [VOLT_W-1:0] rec_val;
  } scan_report_t;

  // tracked copy of the block's limits and scan figures
  logic [VOLT_W-1:0] hi_lim, lo_lim;
  logic [VOLT_W-1:0] run_max;
  logic [VOLT_W:0]   run_min;
  logic [SUM_W-1:0]  run_sum;
  logic [CNT_W-1:0]  cell_cnt;
  logic [CODE_W-1:0] rec_code;
  logic [IDX_W-1:0]  rec_idx;
  logic [VOLT_W-1:0] rec_val;

  scan_report_t scans_due[$];
  scan_report_t want;
  int           n_results;

  task automatic report(input string msg);
    if (mismatch_count < PRINT_CAP) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report($sformatf("scan result %0d, %s: got %0d, expected %0d",
                       n_results, name, got, exp_val));
  endtask

  task automatic clear_scan();
    run_max  = '0;
    run_min  = '1;
    run_sum  = '0;
    cell_cnt = '0;
  endtask

  // Fold one cell into the running figures; close the scan on its last cell or at MAX_CELLS cells.
  task automatic fold_cell(input logic [VOLT_W-1:0] v, input logic is_last);
    scan_report_t     r;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] quot;
    idx = cell_cnt[IDX_W-1:0];
    if (v > run_max) begin
      run_max = v;
      if (v > hi_lim) begin
        rec_code = CODE_OVER;
        rec_idx  = idx;
        rec_val  = v;
      end
    end
    // min check runs second, so an under event wins over an over event on one cell
    if ({1'b0, v} < run_min) begin
      run_min = {1'b0, v};
      if (v < lo_lim) begin
        rec_code = CODE_UNDER;
        rec_idx  = idx;
        rec_val  = v;
      end
    end
    run_sum  = run_sum + SUM_W'(v);
    cell_cnt = cell_cnt + CNT_W'(1);
    if (is_last || cell_cnt == CNT_W'(MAX_CELLS)) begin
      quot       = run_sum / SUM_W'(cell_cnt);
      r.max_v    = run_max;
      r.min_v    = run_min[VOLT_W-1:0];
      r.total_v  = run_sum;
      r.mean_v   = quot[VOLT_W-1:0];
      if (run_max > hi_lim)
        r.status = CODE_OVER;
      else if (run_min < {1'b0, lo_lim})
        r.status = CODE_UNDER;
      else
        r.status = CODE_NONE;
      r.rec_code = rec_code;
      r.rec_idx  = rec_idx;
      r.rec_val  = rec_val;
      scans_due.push_back(r);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hi_lim         = '1;
      lo_lim         = '0;
      rec_code       = CODE_NONE;
      rec_idx        = '0;
      rec_val        = '0;
      n_results      = 0;
      mismatch_count = 0;
      clear_scan();
      scans_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (scans_due.size() == 0) begin
          report($sformatf("scan result %0d arrived with no scan closed", n_results));
        end else begin
          want = scans_due.pop_front();
          check_field("max_voltage",   out_ch.max_voltage,   want.max_v);
          check_field("min_voltage",   out_ch.min_voltage,   want.min_v);
          check_field("total_voltage", out_ch.total_voltage, want.total_v);
          check_field("mean_voltage",  out_ch.mean_voltage,  want.mean_v);
          check_field("scan_status",   out_ch.scan_status,   want.status);
          check_field("record_code",   out_ch.record_code,   want.rec_code);
          check_field("record_index",  out_ch.record_index,  want.rec_idx);
          check_field("record_value",  out_ch.record_value,  want.rec_val);
        end
      end
      if (in_ch.valid && in_ch.ready)
        fold_cell(in_ch.cell_voltage, in_ch.last_cell);
      if (cfg_we) begin
        if (cfg_index == REG_UPPER_LIMIT)
          hi_lim = cfg_data;
        else if (cfg_index == REG_LOWER_LIMIT)
          lo_lim = cfg_data;
      end
    end
    pending_scans = scans_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the cell voltage scan monitor: clock, reset, stimulus and verdict.
// Depends on cvsm_pkg, the channel interfaces, cvsm_scan_checker and the block itself.
module tb;
  import cvsm_pkg::*;

  // Longest legal quiet stretch is a full queue draining through the divider with
  // the receiver stalled; the limit allows many times that stretch.
  localparam int STALL_LIMIT   = 2000;
  // Settle and drain waits cover the back end's load, divide and output steps, with margin.
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_CELLS   = 95;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvsm_in_if  in_ch();
  cvsm_out_if out_ch();

  int mismatch_count;
  int pending_scans;
  int quiet_cycles = 0;

  // Idle switches: when clear, that side runs back to back.
  bit in_idle  = 1'b0;
  bit out_idle = 1'b0;

  // Limits as last written, only to aim samples near them.
  logic [VOLT_W-1:0] hi_aim = '1;
  logic [VOLT_W-1:0] lo_aim = '0;

  always #5 clk = ~clk;

  cell_voltage_scan_monitor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cvsm_scan_checker i_scan_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_scans  (pending_scans)
  );

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: draw a stall per result word, hold ready low for it, then
  // hold ready high until a word is taken.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_idle ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Offer one sample word; return at the falling edge after it was taken.
  // Valid stays high so the next word can follow without a gap.
  task automatic send_cell(input logic [VOLT_W-1:0] v, input logic is_last);
    int gap;
    gap = in_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.cell_voltage = v;
    in_ch.last_cell    = is_last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid, wait until every closed scan has come out and the back end has
  // settled, then write one limit register.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    in_ch.valid = 1'b0;
    while (pending_scans != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == REG_UPPER_LIMIT) hi_aim = value;
    else lo_aim = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [VOLT_W-1:0] near(input logic [VOLT_W-1:0] lim);
    int t;
    t = int'(lim) + $urandom_range(0, 8) - 4;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t[VOLT_W-1:0];
  endfunction

  // Mix rails, values around both limits and the full range.
  function automatic logic [VOLT_W-1:0] pick_voltage();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return near(hi_aim);
      4, 5:    return near(lo_aim);
      default: return VOLT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Send len cells; flag the last one only when the scan is to be closed.
  task automatic send_scan(input int len, input bit close);
    for (int i = 0; i < len; i++)
      send_cell(pick_voltage(), close && (i == len - 1));
  endtask

  initial begin : stimulus
    int sent;
    int len;
    in_ch.valid        = 1'b0;
    in_ch.cell_voltage = '0;
    in_ch.last_cell    = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_UPPER_LIMIT;
    cfg_data           = '0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Reset limits: single-cell scans at both rails, then a repeated sample
    // that must not count as a new maximum.
    send_cell(16'd0, 1'b1);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'd100, 1'b0);
    send_cell(16'd100, 1'b0);
    send_cell(16'd50, 1'b1);

    // Overvoltage then undervoltage in one scan: the newer event holds the record,
    // and status still reports over first.
    write_limit(REG_UPPER_LIMIT, 16'd1000);
    write_limit(REG_LOWER_LIMIT, 16'd200);
    send_cell(16'd500, 1'b0);
    send_cell(16'd1500, 1'b0);
    send_cell(16'd1500, 1'b0);
    send_cell(16'd100, 1'b0);
    send_cell(16'd100, 1'b0);
    send_cell(16'd600, 1'b1);
    // A good scan keeps the old record.
    send_cell(16'd300, 1'b1);

    // Limit changes in the middle of a scan: the record uses the limit at its
    // cell, the status the limit at the closing cell.
    send_cell(16'd700, 1'b0);
    send_cell(16'd900, 1'b0);
    write_limit(REG_UPPER_LIMIT, 16'd800);
    send_cell(16'd850, 1'b0);
    write_limit(REG_UPPER_LIMIT, 16'hFFFF);
    send_cell(16'd400, 1'b1);

    // One cell that is both a new max above the upper limit and a new min below
    // the lower limit: the under event overwrites the over event.
    write_limit(REG_UPPER_LIMIT, 16'd10);
    write_limit(REG_LOWER_LIMIT, 16'd60000);
    send_cell(16'd30000, 1'b1);

    // Extreme limits.
    write_limit(REG_UPPER_LIMIT, 16'd0);
    write_limit(REG_LOWER_LIMIT, 16'hFFFF);
    send_cell(16'd0, 1'b0);
    send_cell(16'hFFFF, 1'b1);

    // Overlong scan at full scale: the count closes it at MAX_CELLS with the
    // largest total, and the following cells open a new scan.
    write_limit(REG_UPPER_LIMIT, 16'hFFFF);
    write_limit(REG_LOWER_LIMIT, 16'd0);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    for (int i = 0; i < MAX_CELLS; i++)
      send_cell(16'hFFFF, 1'b0);
    send_cell(16'd1, 1'b0);
    send_cell(16'd2, 1'b0);
    send_cell(16'd3, 1'b1);

    // Random phases: fresh limits and idle pattern each time, scans mostly short,
    // a few near MAX_CELLS long; a phase may end inside an open scan so that the next limit
    // write lands mid-scan.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_limit(REG_UPPER_LIMIT, pick_limit());
      write_limit(REG_LOWER_LIMIT, pick_limit());
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_CELLS) begin
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 12);
        send_scan(len, 1'b1);
        sent += len;
      end
      if ($urandom_range(0, 1) == 1)
        send_scan($urandom_range(1, 4), 1'b0);
    end
    // Close whatever scan is left open.
    send_cell(pick_voltage(), 1'b1);

    // Drain: drop valid, wait for every result, then let the back end settle.
    in_ch.valid = 1'b0;
    while (pending_scans != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* cell_voltage_scan_monitor_top.f */
+incdir+design
design/cvsm_pkg.sv
design/cvsm_ifs.sv
design/cvsm_front.sv
design/cvsm_queue.sv
design/cvsm_back.sv
design/cell_voltage_scan_monitor_top.sv
design/cvsm_checker.sv
tb/cvsm_scan_checker.sv
tb/tb.sv
